// ----- rtl/brwl_pkg.sv -----
`default_nettype none

package brwl_pkg;

    // Generator geometry
    localparam int WORD_COUNT          = 11;
    localparam int ADVANCES_PER_REFILL = 13;
    localparam int BITS_PER_WORD       = 30;
    localparam int STOP_WORD           = 5;
    localparam int STOP_BIT            = 15;
    localparam int MAX_ATTEMPTS        = 4096;

    // Field and register widths
    localparam int RANGE_W = 7;
    localparam int VALUE_W = 6;
    localparam int MULT_W  = 16;
    localparam int INCR_W  = 30;
    localparam int CFG_W   = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [MULT_W-1:0] MULT_RESET = 16'd33343;
    localparam logic [INCR_W-1:0] INCR_RESET = 30'd902761;
    localparam logic [RANGE_W-1:0] RANGE_MAX = 7'd64;

    // Derived widths
    localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_IDX_W  = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
    localparam int REP_W      = (ADVANCES_PER_REFILL > 1) ? $clog2(ADVANCES_PER_REFILL) : 1;
    localparam int ATTEMPT_W  = $clog2(MAX_ATTEMPTS);
    localparam int PROD_W     = MULT_W + BITS_PER_WORD;
    localparam int SUM_W      = INCR_W + 1;

    typedef logic [BITS_PER_WORD-1:0] lcg_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULTIPLIER = 1'b0,
        CFG_INCREMENT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_MUL,
        ST_ADD
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic refill_start;
        logic mul;
        logic add;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_range;
        logic at_stop;
        logic finish;
        logic out_free;
        logic last_word;
        logic last_rep;
    } dp_stat_t;

    function automatic lcg_word_t seed_word(input logic [WORD_IDX_W-1:0] idx);
        logic [31:0] s;
        case (idx)
            4'd0:    s = 32'd1276095297;
            4'd1:    s = 32'd1191902957;
            4'd2:    s = 32'd1599290432;
            4'd3:    s = 32'd693925063;
            4'd4:    s = 32'd569902669;
            4'd5:    s = 32'd677092687;
            4'd6:    s = 32'd1938724611;
            4'd7:    s = 32'd969352630;
            4'd8:    s = 32'd1659091758;
            4'd9:    s = 32'd671380899;
            4'd10:   s = 32'd1719302732;
            default: s = 32'd0;
        endcase
        return s[BITS_PER_WORD-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/brwl_ctrl.sv -----
`default_nettype none

module brwl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire brwl_pkg::dp_stat_t stat,
    output brwl_pkg::dp_cmd_t       cmd
);
    import brwl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                // a zero range returns before any bit is read
                if (stat.at_stop && !stat.zero_range)
                begin
                    cmd.refill_start = 1'b1;
                    state_next       = ST_MUL;
                end
                else if (!stat.finish || stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.finish)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (stat.last_word && stat.last_rep)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/brwl_dp.sv -----
`default_nettype none

module brwl_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [brwl_pkg::RANGE_W-1:0]   range_size,
    output logic      [brwl_pkg::VALUE_W-1:0]   random_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    input  wire logic                           cfg_valid,
    input  wire logic [brwl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [brwl_pkg::CFG_W-1:0]     cfg_data,
    input  wire brwl_pkg::dp_cmd_t              cmd,
    output brwl_pkg::dp_stat_t                  stat
);
    import brwl_pkg::*;

    lcg_word_t                  words_reg [WORD_COUNT];
    logic [WORD_IDX_W-1:0]      word_ptr_reg;
    logic [BIT_IDX_W-1:0]       bit_ptr_reg;
    logic [MULT_W-1:0]          mult_reg;
    logic [INCR_W-1:0]          incr_reg;

    logic [RANGE_W-1:0]         n_reg;
    logic [VALUE_W-1:0]         r_reg;
    logic [VALUE_W-1:0]         v_reg;
    logic [ATTEMPT_W-1:0]       attempt_reg;

    logic [WORD_IDX_W-1:0]      adv_idx_reg;
    logic [REP_W-1:0]           rep_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [MULT_W-1:0]          mc_reg;
    logic [INCR_W-1:0]          ac_reg;

    logic [VALUE_W-1:0]         value_reg;
    logic                       out_valid_reg;

    logic [WORD_IDX_W-1:0]      rd_addr;
    lcg_word_t                  rd_word;
    logic                       bit_val;
    logic [RANGE_W-1:0]         r_new;
    logic [VALUE_W-1:0]         v_new;
    logic                       draw_end;
    logic                       accept;
    logic                       last_attempt;
    logic [VALUE_W-1:0]         result;
    logic [VALUE_W-1:0]         v_top;
    logic [PROD_W-1:0]          mac;
    logic [SUM_W-1:0]           sum;
    logic                       load_out;

    // weight of the first bit of a draw: ceil(log2 n) bits, at least one
    function automatic logic [VALUE_W-1:0] top_weight(input logic [RANGE_W-1:0] n);
        logic [VALUE_W-1:0] w;
        if (n <= 7'd2)
            w = 6'd1;
        else if (n <= 7'd4)
            w = 6'd2;
        else if (n <= 7'd8)
            w = 6'd4;
        else if (n <= 7'd16)
            w = 6'd8;
        else if (n <= 7'd32)
            w = 6'd16;
        else
            w = 6'd32;
        return w;
    endfunction

    assign v_top   = top_weight(n_reg);
    assign rd_addr = cmd.mul ? adv_idx_reg : word_ptr_reg;
    assign rd_word = words_reg[rd_addr];
    assign bit_val = rd_word[bit_ptr_reg];

    assign r_new        = {1'b0, r_reg} + {1'b0, (bit_val ? v_reg : {VALUE_W{1'b0}})};
    assign v_new        = v_reg >> 1;
    assign draw_end     = (v_new == '0) || (r_new >= n_reg);
    assign accept       = (r_new < n_reg);
    assign last_attempt = (attempt_reg == ATTEMPT_W'(MAX_ATTEMPTS - 1));
    assign result       = accept ? r_new[VALUE_W-1:0] : {VALUE_W{1'b0}};

    assign mac = prod_reg + {{(PROD_W-MULT_W){1'b0}}, mc_reg};
    assign sum = {{(SUM_W-BITS_PER_WORD){1'b0}}, mac[BITS_PER_WORD-1:0]}
               + {1'b0, ac_reg};

    assign stat.zero_range = (n_reg == '0);
    assign stat.at_stop    = (word_ptr_reg == WORD_IDX_W'(STOP_WORD))
                          && (bit_ptr_reg == BIT_IDX_W'(STOP_BIT));
    assign stat.finish     = (n_reg == '0) || (draw_end && (accept || last_attempt));
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.last_word  = (adv_idx_reg == WORD_IDX_W'(WORD_COUNT - 1));
    assign stat.last_rep   = (rep_reg == REP_W'(ADVANCES_PER_REFILL - 1));

    assign load_out     = cmd.step && stat.finish;
    assign out_valid    = out_valid_reg;
    assign random_value = value_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            incr_reg <= INCR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MULTIPLIER: mult_reg <= cfg_data[MULT_W-1:0];
                CFG_INCREMENT:  incr_reg <= cfg_data[INCR_W-1:0];
                default:        ;
            endcase
        end
    end

    // generator state and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                words_reg[i] <= seed_word(WORD_IDX_W'(i));
            end
            word_ptr_reg <= WORD_IDX_W'(WORD_COUNT - 1);
            bit_ptr_reg  <= BIT_IDX_W'(BITS_PER_WORD - 1);
            rep_reg      <= '0;
            adv_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.refill_start)
            begin
                adv_idx_reg <= '0;
                rep_reg     <= '0;
            end
            else if (cmd.add)
            begin
                words_reg[adv_idx_reg] <= sum[BITS_PER_WORD-1:0];
                if (stat.last_word)
                begin
                    adv_idx_reg <= '0;
                    if (stat.last_rep)
                    begin
                        rep_reg      <= '0;
                        word_ptr_reg <= WORD_IDX_W'(WORD_COUNT - 1);
                        bit_ptr_reg  <= BIT_IDX_W'(BITS_PER_WORD - 1);
                    end
                    else
                    begin
                        rep_reg <= rep_reg + 1'b1;
                    end
                end
                else
                begin
                    adv_idx_reg <= adv_idx_reg + 1'b1;
                end
            end
            else if (cmd.step && !stat.zero_range)
            begin
                // advance the pointer one bit, wrapping to the top word
                if (bit_ptr_reg == '0)
                begin
                    bit_ptr_reg  <= BIT_IDX_W'(BITS_PER_WORD - 1);
                    word_ptr_reg <= (word_ptr_reg == '0) ? WORD_IDX_W'(WORD_COUNT - 1)
                                                         : word_ptr_reg - 1'b1;
                end
                else
                begin
                    bit_ptr_reg <= bit_ptr_reg - 1'b1;
                end
            end
        end
    end

    // multiply-accumulate carries; the carry of the increment starts at c
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mult_reg) * PROD_W'(rd_word);
        end
        if (cmd.refill_start || (cmd.add && stat.last_word))
        begin
            mc_reg <= '0;
            ac_reg <= incr_reg;
        end
        else if (cmd.add)
        begin
            mc_reg <= mac[PROD_W-1:BITS_PER_WORD];
            ac_reg <= INCR_W'(sum >> BITS_PER_WORD);
        end
    end

    // draw registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg       <= (range_size > RANGE_MAX) ? RANGE_MAX : range_size;
            r_reg       <= '0;
            v_reg       <= top_weight((range_size > RANGE_MAX) ? RANGE_MAX : range_size);
            attempt_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (draw_end && !stat.finish)
            begin
                // reject and draw again
                r_reg       <= '0;
                v_reg       <= v_top;
                attempt_reg <= attempt_reg + 1'b1;
            end
            else
            begin
                r_reg <= r_new[VALUE_W-1:0];
                v_reg <= v_new;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg <= stat.zero_range ? {VALUE_W{1'b0}} : result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bounded_random_from_wide_lcg_unit.sv -----
// A range size of 0 gives its item without reading a bit; otherwise bits are read one at a
// time (1 to 6 per draw, repeated on rejection). When the read pointer reaches word 5 bit 15,
// a refill runs first: a setup step, then 13 advances of 11 words, each word a multiply and
// an add on one 16x30 multiplier. A finished result waits while the output register holds
// a stalled item. The next request is taken the cycle after a result; the output register
// lets it start while a result waits. Reset: state words to the seed table, pointer to 10/29.
`default_nettype none

module bounded_random_from_wide_lcg_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [brwl_pkg::RANGE_W-1:0]   range_size,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [brwl_pkg::VALUE_W-1:0]   random_value,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [brwl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [brwl_pkg::CFG_W-1:0]     cfg_data
);
    import brwl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    brwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    brwl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .range_size   (range_size),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire
